FILE: rtl/wksnd_pkg.sv
`default_nettype none

package wksnd_pkg;

    localparam int KeyW      = 12;
    localparam int MaskW     = 13;
    localparam int NoteW     = 9;
    localparam int OffsetW   = 7;
    localparam int BaseW     = 7;
    localparam int InDataW   = 16;
    localparam int OutDataW  = 40;

    localparam int RepeatDelayDefault = 15;
    localparam logic [BaseW-1:0] BaseNoteReset = 7'd61;
    localparam logic signed [NoteW-1:0] NoteBias = 9'sd13;

    localparam int KeyLowC    = 0;
    localparam int KeyEb      = 1;
    localparam int KeyD       = 2;
    localparam int KeyE       = 3;
    localparam int KeyF       = 4;
    localparam int KeyLowCs   = 5;
    localparam int KeyGs      = 6;
    localparam int KeyG       = 7;
    localparam int KeyA       = 8;
    localparam int KeyB       = 9;
    localparam int KeyOctUp   = 10;
    localparam int KeyOctDown = 11;

    localparam int MaskOctDown = 10;
    localparam int MaskOctUp   = 11;
    localparam int MaskMenu    = 12;

    typedef logic signed [OffsetW-1:0] t_offset;

    typedef struct packed {
        logic [MaskW-1:0] pressed;
        logic [MaskW-1:0] push;
        logic             bend;
    } t_scan_res;

endpackage

`default_nettype wire

FILE: rtl/wksnd_finger.sv
`default_nettype none

module wksnd_finger
    import wksnd_pkg::*;
(
    input  wire logic [KeyW-1:0] i_down,
    output t_offset              o_offset
);

    logic c, eb, d, e, f, cs, gs, b, up, dn;
    logic [2:0] top;
    t_offset base_n;
    t_offset n;

    assign c   = i_down[KeyLowC];
    assign eb  = i_down[KeyEb];
    assign d   = i_down[KeyD];
    assign e   = i_down[KeyE];
    assign f   = i_down[KeyF];
    assign cs  = i_down[KeyLowCs];
    assign gs  = i_down[KeyGs];
    assign b   = i_down[KeyB];
    assign up  = i_down[KeyOctUp];
    assign dn  = i_down[KeyOctDown];
    assign top = {i_down[KeyG], i_down[KeyA], i_down[KeyB]};

    always_comb begin
        base_n = '0;
        unique case (top)
            3'd7, 3'd6: begin
                priority if (c && d && e && f) begin
                    base_n = eb ? 7'sd2 : 7'sd0;
                end else if (d && e && f) begin
                    base_n = 7'sd2;
                end else if (e && f) begin
                    base_n = 7'sd4;
                end else if (f) begin
                    base_n = 7'sd5 - (c ? 7'sd2 : 7'sd0);
                end else begin
                    base_n = 7'sd7 - (c ? 7'sd2 : 7'sd0) - (e ? 7'sd1 : 7'sd0);
                end
                if (!b) begin
                    base_n = base_n + 7'sd12;
                end
            end
            3'd3: base_n = 7'sd9 - (c ? 7'sd2 : 7'sd0) - (e ? 7'sd1 : 7'sd0)
                           + (f ? 7'sd1 : 7'sd0);
            3'd1: base_n = 7'sd11 - (c ? 7'sd2 : 7'sd0) - (e ? 7'sd1 : 7'sd0)
                           - (f ? 7'sd1 : 7'sd0);
            3'd2: base_n = 7'sd12 - (c ? 7'sd2 : 7'sd0) + (d ? 7'sd2 : 7'sd0)
                           - (e ? 7'sd1 : 7'sd0) - (f ? 7'sd1 : 7'sd0);
            3'd4: base_n = 7'sd20 - (c ? 7'sd2 : 7'sd0) + (d ? 7'sd2 : 7'sd0)
                           - (e ? 7'sd1 : 7'sd0) - (f ? 7'sd1 : 7'sd0);
            3'd5: base_n = 7'sd10 - (c ? 7'sd2 : 7'sd0) + (d ? 7'sd2 : 7'sd0)
                           - (e ? 7'sd1 : 7'sd0) - (f ? 7'sd1 : 7'sd0);
            default: base_n = 7'sd13 + (d ? 7'sd2 : 7'sd0) - (e ? 7'sd1 : 7'sd0)
                              - (f ? 7'sd1 : 7'sd0);
        endcase
    end

    always_comb begin
        n = base_n;
        if (eb && !c) begin
            n = n + 7'sd1;
        end
        if (gs) begin
            n = n + 7'sd1;
        end
        if (cs) begin
            n = n - 7'sd1;
        end
        if (up) begin
            n = n + 7'sd12;
        end else if (dn) begin
            n = n - 7'sd12;
        end
    end

    assign o_offset = n;

endmodule

`default_nettype wire

FILE: rtl/wksnd_scan.sv
`default_nettype none

module wksnd_scan
    import wksnd_pkg::*;
#(
    parameter int REPEAT_DELAY = RepeatDelayDefault
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [KeyW-1:0] i_down,
    input  wire logic            i_menu_down,
    input  wire logic            i_repeat_enable,
    output t_scan_res            o_res
);

    localparam int CountW = $clog2(REPEAT_DELAY + 3);
    localparam logic [CountW:0] DelayVal = (CountW + 1)'(REPEAT_DELAY);
    localparam logic [CountW:0] WrapTop  = (CountW + 1)'(REPEAT_DELAY + 2);
    localparam logic [CountW:0] WrapLow  = (CountW + 1)'(REPEAT_DELAY + 1);

    logic [MaskW-1:0]  r_prev_mask, n_prev_mask;
    logic [CountW-1:0] r_count, n_count;
    logic [MaskW-1:0]  mask;
    logic [CountW:0]   step;
    logic              held;

    assign mask = {i_menu_down, i_down[KeyOctUp], i_down[KeyOctDown], i_down[KeyB:KeyLowC]};
    assign held = i_repeat_enable && (mask != '0) && (mask == r_prev_mask);

    always_comb begin
        step = {1'b0, r_count} + 1'b1;
        if (step > WrapTop) begin
            step = WrapLow;
        end
        o_res.pressed = mask;
        o_res.push    = mask & ~r_prev_mask;
        o_res.bend    = i_down[KeyLowC] & i_down[KeyEb];
        n_count       = '0;
        n_prev_mask   = mask;
        if (held) begin
            n_count = step[CountW-1:0];
            if (step > DelayVal && !step[0]) begin
                o_res.push = mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mask <= '0;
            r_count     <= '0;
        end else if (i_take) begin
            r_prev_mask <= n_prev_mask;
            r_count     <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/wind_key_scan_note_decode_core.sv
`default_nettype none

// Key scanner and fingering decoder for a wind controller. Each input beat is
// one scan tick and yields exactly one registered output beat in the cycle after
// it is taken; a new beat is accepted in every cycle while the output register
// is free or being emptied, so the block sustains one tick per cycle. The push
// mask comes from the edge and repeat registers, and the note is base_note
// minus thirteen plus the fingering offset. base_note may be written at any
// time the block is idle and takes effect from the next beat.

module wind_key_scan_note_decode_core
    import wksnd_pkg::*;
#(
    parameter int REPEAT_DELAY = RepeatDelayDefault
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    // raw_keys, menu_key, repeat_enable
    input  wire logic [InDataW-1:0]  i_s_tdata,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    // pressed_mask, push_mask, note_number, bend_keys
    output logic [OutDataW-1:0]      o_m_tdata,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [BaseW-1:0]    i_cfg_data
);

    logic [BaseW-1:0]         r_base_note;
    logic                     r_out_valid;
    logic [MaskW-1:0]         r_pressed, r_push;
    logic signed [NoteW-1:0]  r_note, n_note;
    logic                     r_bend;
    logic                     take;
    logic [KeyW-1:0]          down;
    t_offset                  offset;
    t_scan_res                scan_res;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign take        = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign down        = ~i_s_tdata[KeyW-1:0];

    wksnd_scan #(
        .REPEAT_DELAY(REPEAT_DELAY)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_down         (down),
        .i_menu_down    (!i_s_tdata[KeyW]),
        .i_repeat_enable(i_s_tdata[KeyW+1]),
        .o_res          (scan_res)
    );

    wksnd_finger u_finger (
        .i_down  (down),
        .o_offset(offset)
    );

    assign n_note = $signed({2'b00, r_base_note}) - NoteBias
                    + NoteW'(offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_note <= BaseNoteReset;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base_note <= i_cfg_data;
            end
            if (o_s_tready) begin
                r_out_valid <= i_s_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pressed <= scan_res.pressed;
            r_push    <= scan_res.push;
            r_note    <= n_note;
            r_bend    <= scan_res.bend;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_bend, r_note, r_push, r_pressed};

    a_accept_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_m_tvalid
    ) else $error("accepted beat produced no result");

    a_push_within_pressed: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((r_push & ~r_pressed) == '0)
    ) else $error("push mask holds a key that is not pressed");

    a_bend_needs_keys: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_bend) |-> (r_pressed[KeyLowC] && r_pressed[KeyEb])
    ) else $error("bend flag without low C and Eb pressed");

    a_stall_holds_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata))
    ) else $error("result changed while stalled");

endmodule

`default_nettype wire
